FILE: design/efg_pkg.sv
// Shared types and codes for the event flag group.
package efg_pkg;

  typedef enum logic [2:0] {
    OP_POST    = 3'd0,
    OP_PEND_NB = 3'd1,
    OP_PEND_BL = 3'd2,
    OP_TIMEOUT = 3'd3,
    OP_BREAK   = 3'd4,
    OP_DELETE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_QUEUE_FULL  = 3'd3,
    ST_TIMED_OUT   = 3'd4,
    ST_INTERRUPTED = 3'd5,
    ST_REMOVED     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ANSWER,
    S_WAIT_OUT
  } state_t;

  localparam logic KIND_CALLER  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam int unsigned REG_INITIAL_FLAGS = 0;

  // Command word passed from the front end to the back end.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] mask;
    logic        wait_mode;
    logic [7:0]  task_id;
  } cmd_t;

endpackage

FILE: design/efg_front.sv
// Front end: accepts beats, drops unused op codes, holds a two-entry command queue.
module efg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_op,
  input  logic [31:0]   in_mask,
  input  logic          in_wait_mode,
  input  logic [7:0]    in_task_id,
  input  logic [31:0]   fmask,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output efg_pkg::cmd_t cmd
);

  efg_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push, pop, legal;

  assign legal    = (in_op <= 3'(efg_pkg::OP_DELETE));
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && legal;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop      = cmd_valid && cmd_ready;
  assign cmd      = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) begin
      q_r[wr_r] <= '{op: in_op, mask: in_mask & fmask, wait_mode: in_wait_mode,
                     task_id: in_task_id};
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("front queue overflow");

endmodule

FILE: design/efg_back.sv
// Back end: flag word, waiter queue and the per-command scan sequencer.
module efg_back #(
  parameter int MAX_WAITERS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  efg_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_flags,
  output logic [31:0]   flags,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_kind,
  output logic [7:0]    out_who,
  output logic [31:0]   out_granted_mask,
  output logic [2:0]    out_status,
  output logic [31:0]   out_flags_now,
  output logic [3:0]    out_sleepers,
  output logic          out_last
);

  localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CW = $clog2(MAX_WAITERS + 1);

  efg_pkg::state_t state_r, state_nxt;

  logic [31:0] flags_r;
  logic [31:0] wmask_r [MAX_WAITERS];
  logic        wany_r  [MAX_WAITERS];
  logic [7:0]  wtask_r [MAX_WAITERS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  efg_pkg::cmd_t cur_r;

  // output register
  logic        ov_r;
  logic        ok_r, olast_r;
  logic [7:0]  owho_r;
  logic [31:0] ogr_r, ofl_r;
  logic [2:0]  ost_r;
  logic [3:0]  osl_r;

  logic        obusy;
  logic        in_range;
  logic [IW-1:0] ix;
  logic [31:0] want, have;
  logic        hit;
  logic        emit, emit_last, remove;
  logic        e_kind;
  logic [7:0]  e_who;
  logic [31:0] e_gr, flags_next;
  logic [2:0]  e_st;
  logic [CW-1:0] count_next;
  logic        push_w;

  assign flags     = flags_r;
  assign obusy     = ov_r && !out_ready;
  assign in_range  = (idx_r < count_r);
  assign ix        = idx_r[IW-1:0];
  assign want      = wmask_r[ix];
  assign have      = want & flags_r;
  assign cmd_ready = (state_r == efg_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      efg_pkg::S_IDLE:     if (cmd_valid) state_nxt = efg_pkg::S_SCAN;
      efg_pkg::S_SCAN:     if (!obusy && emit_last) state_nxt = efg_pkg::S_WAIT_OUT;
                           else if (!obusy && !in_range) state_nxt = efg_pkg::S_ANSWER;
      efg_pkg::S_ANSWER:   if (!obusy) state_nxt = efg_pkg::S_WAIT_OUT;
      efg_pkg::S_WAIT_OUT: if (!obusy) state_nxt = efg_pkg::S_IDLE;
      default:             state_nxt = efg_pkg::S_IDLE;
    endcase
  end

  // datapath actions for the current step
  always_comb begin
    emit = 1'b0; emit_last = 1'b0; remove = 1'b0; push_w = 1'b0;
    e_kind = efg_pkg::KIND_CALLER; e_who = cur_r.task_id; e_gr = '0;
    e_st = efg_pkg::ST_OK;
    flags_next = flags_r; count_next = count_r;
    hit = wany_r[ix] ? (have != '0) : (have == want);
    case (state_r)
      efg_pkg::S_IDLE: begin
        // a post ORs its bits in as it is taken, before the walk
        if (cmd_valid && cmd.op == 3'(efg_pkg::OP_POST)) flags_next = flags_r | cmd.mask;
      end
      efg_pkg::S_SCAN: begin
        if (!obusy && in_range) begin
          case (cur_r.op)
            3'(efg_pkg::OP_POST): begin
              if (hit) begin
                emit = 1'b1; remove = 1'b1; e_kind = efg_pkg::KIND_RELEASE;
                e_who = wtask_r[ix]; e_gr = have; flags_next = flags_r & ~want;
              end
            end
            3'(efg_pkg::OP_TIMEOUT), 3'(efg_pkg::OP_BREAK): begin
              if (wtask_r[ix] == cur_r.task_id) begin
                emit = 1'b1; emit_last = 1'b1; remove = 1'b1;
                e_kind = efg_pkg::KIND_RELEASE; e_gr = want;
                e_st = (cur_r.op == 3'(efg_pkg::OP_TIMEOUT)) ?
                       efg_pkg::ST_TIMED_OUT : efg_pkg::ST_INTERRUPTED;
              end
            end
            3'(efg_pkg::OP_DELETE): begin
              emit = 1'b1; remove = 1'b1; e_kind = efg_pkg::KIND_RELEASE;
              e_who = wtask_r[ix]; e_gr = want; e_st = efg_pkg::ST_REMOVED;
            end
            default: ;
          endcase
          if (remove) count_next = count_r - CW'(1);
        end
      end
      efg_pkg::S_ANSWER: begin
        if (!obusy) begin
          emit = 1'b1; emit_last = 1'b1;
          hit = cur_r.wait_mode ? ((flags_r & cur_r.mask) != '0)
                                : ((flags_r & cur_r.mask) == cur_r.mask);
          case (cur_r.op)
            3'(efg_pkg::OP_POST): ;
            3'(efg_pkg::OP_PEND_NB): begin
              e_gr = flags_r & cur_r.mask; flags_next = flags_r & ~cur_r.mask;
              e_st = hit ? efg_pkg::ST_OK : efg_pkg::ST_WOULD_BLOCK;
            end
            3'(efg_pkg::OP_PEND_BL): begin
              if (hit) begin
                e_gr = flags_r & cur_r.mask; flags_next = flags_r & ~cur_r.mask;
              end else if (count_r < CW'(MAX_WAITERS)) begin
                push_w = 1'b1; count_next = count_r + CW'(1); e_st = efg_pkg::ST_QUEUED;
              end else begin
                e_st = efg_pkg::ST_QUEUE_FULL;
              end
            end
            3'(efg_pkg::OP_TIMEOUT), 3'(efg_pkg::OP_BREAK): e_st = efg_pkg::ST_WOULD_BLOCK;
            3'(efg_pkg::OP_DELETE): flags_next = '0;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efg_pkg::S_IDLE;
      flags_r <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_next;
      if (cfg_we) flags_r <= cfg_flags;
      else        flags_r <= flags_next;
      if (emit)            ov_r <= 1'b1;
      else if (out_ready)  ov_r <= 1'b0;
    end
    if (state_r == efg_pkg::S_IDLE) begin
      cur_r <= cmd;
      idx_r <= '0;
    end else if (state_r == efg_pkg::S_SCAN && !obusy && in_range && !remove) begin
      idx_r <= idx_r + CW'(1);
    end
    // shift the queue down over a removed entry
    if (remove) begin
      for (int j = 0; j < MAX_WAITERS - 1; j++) begin
        if (j >= int'(ix)) begin
          wmask_r[j] <= wmask_r[j+1];
          wany_r[j]  <= wany_r[j+1];
          wtask_r[j] <= wtask_r[j+1];
        end
      end
    end
    if (push_w) begin
      wmask_r[count_r[IW-1:0]] <= cur_r.mask;
      wany_r[count_r[IW-1:0]]  <= cur_r.wait_mode;
      wtask_r[count_r[IW-1:0]] <= cur_r.task_id;
    end
    if (emit) begin
      ok_r    <= e_kind;
      owho_r  <= e_who;
      ogr_r   <= e_gr;
      ost_r   <= e_st;
      ofl_r   <= flags_next;
      osl_r   <= 4'(count_next);
      olast_r <= emit_last;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = ok_r;
  assign out_who          = owho_r;
  assign out_granted_mask = ogr_r;
  assign out_status       = ost_r;
  assign out_flags_now    = ofl_r;
  assign out_sleepers     = osl_r;
  assign out_last         = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_WAITERS)) else $error("waiter count over depth");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    obusy |-> !emit) else $error("result overwritten while stalled");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != efg_pkg::S_IDLE) |-> !cmd_ready) else $error("command taken mid-flight");

endmodule

FILE: design/event_flag_group.sv
// Event flag group: flag word plus FIFO of waiting tasks.
// A command is registered in the front-end command queue before the back end takes it; every op
// walks the n queued waiters one per cycle while the output is not stalled, except that a timeout
// or break stops at the first waiter of its task. The back end takes a new command only once the
// last result of the previous one has left the output register; the two-entry command
// queue keeps accepting while it works. Synchronous reset clears flags and the queue count.
module event_flag_group #(
  parameter int MAX_WAITERS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_mask,
  input  logic        in_wait_mode,
  input  logic [7:0]  in_task_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_who,
  output logic [31:0] out_granted_mask,
  output logic [2:0]  out_status,
  output logic [31:0] out_flags_now,
  output logic [3:0]  out_sleepers,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  efg_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;
  logic [31:0]   flags;
  logic          cfg_we;

  // only register: initial_flags at address 0; a write loads the flag word
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[1:0] == 2'(efg_pkg::REG_INITIAL_FLAGS));
  assign prdata = flags;

  efg_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_mask, .in_wait_mode,
    .in_task_id, .fmask(32'hFFFF_FFFF), .cmd_valid, .cmd_ready, .cmd
  );

  efg_back #(.MAX_WAITERS(MAX_WAITERS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .cfg_we, .cfg_flags(pwdata), .flags,
    .out_valid, .out_ready, .out_kind, .out_who, .out_granted_mask, .out_status,
    .out_flags_now, .out_sleepers, .out_last
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the event flag group: driver, monitor and flag/waiter predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int NWAIT = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] mask;
    logic        wait_mode;
    logic [7:0]  task_id;
  } call_t;

  typedef struct {
    logic        kind;
    logic [7:0]  who;
    logic [31:0] granted;
    logic [2:0]  status;
    logic [31:0] flags_now;
    logic [3:0]  sleepers;
    logic        last;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [31:0] in_mask = '0;
  logic        in_wait_mode = 1'b0;
  logic [7:0]  in_task_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_who;
  logic [31:0] out_granted_mask;
  logic [2:0]  out_status;
  logic [31:0] out_flags_now;
  logic [3:0]  out_sleepers;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  event_flag_group DUT (.*);

  always #5 clk = ~clk;

  // Predictor state: flag word plus FIFO of waiting tasks.
  logic [31:0] flag_word;
  logic [31:0] wait_mask [NWAIT];
  logic        wait_any  [NWAIT];
  logic [7:0]  wait_task [NWAIT];
  int          wait_cnt;

  call_t   pending_calls[$];
  answer_t expected_answers[$];
  int      mismatches = 0;
  bit      hold_sender = 1'b0;   // pause the driver while set
  bit      hold_receiver = 1'b0; // long back-pressure stretch
  int      idle_cycles = 0;

  function automatic bit request_met(logic [31:0] want, logic any);
    if (any) return (want & flag_word) != 0;
    return (want & flag_word) == want;
  endfunction

  function automatic void drop_sleeper(int idx);
    for (int j = idx; j + 1 < wait_cnt; j++) begin
      wait_mask[j] = wait_mask[j+1];
      wait_any[j]  = wait_any[j+1];
      wait_task[j] = wait_task[j+1];
    end
    wait_cnt--;
  endfunction

  function automatic void push_answer(logic kind, logic [7:0] who, logic [31:0] got,
                                      efg_pkg::status_t st);
    answer_t a;
    a.kind = kind; a.who = who; a.granted = got; a.status = st;
    a.flags_now = flag_word; a.sleepers = wait_cnt[3:0]; a.last = 1'b0;
    expected_answers.push_back(a);
  endfunction

  // Work out every result one accepted call causes.
  function automatic void predict_call(call_t c);
    int i;
    logic [31:0] got;
    logic [31:0] want;
    logic [7:0] who;
    int prior_cnt;
    prior_cnt = expected_answers.size();
    case (c.op)
      efg_pkg::OP_POST: begin
        flag_word |= c.mask;
        i = 0;
        while (i < wait_cnt) begin
          want = wait_mask[i];
          if (request_met(want, wait_any[i])) begin
            got = want & flag_word;
            who = wait_task[i];
            flag_word &= ~want;
            drop_sleeper(i);
            push_answer(efg_pkg::KIND_RELEASE, who, got, efg_pkg::ST_OK);
          end else i++;
        end
        push_answer(efg_pkg::KIND_CALLER, c.task_id, '0, efg_pkg::ST_OK);
      end
      efg_pkg::OP_PEND_NB: begin
        got = flag_word & c.mask;
        flag_word &= ~c.mask;
        push_answer(efg_pkg::KIND_CALLER, c.task_id, got,
                    (c.wait_mode ? got != 0 : got == c.mask) ?
                    efg_pkg::ST_OK : efg_pkg::ST_WOULD_BLOCK);
      end
      efg_pkg::OP_PEND_BL: begin
        if (request_met(c.mask, c.wait_mode)) begin
          got = flag_word & c.mask;
          flag_word &= ~c.mask;
          push_answer(efg_pkg::KIND_CALLER, c.task_id, got, efg_pkg::ST_OK);
        end else if (wait_cnt < NWAIT) begin
          wait_mask[wait_cnt] = c.mask;
          wait_any[wait_cnt]  = c.wait_mode;
          wait_task[wait_cnt] = c.task_id;
          wait_cnt++;
          push_answer(efg_pkg::KIND_CALLER, c.task_id, '0, efg_pkg::ST_QUEUED);
        end else push_answer(efg_pkg::KIND_CALLER, c.task_id, '0, efg_pkg::ST_QUEUE_FULL);
      end
      efg_pkg::OP_TIMEOUT, efg_pkg::OP_BREAK: begin
        for (i = 0; i < wait_cnt; i++) if (wait_task[i] == c.task_id) break;
        if (i < wait_cnt) begin
          want = wait_mask[i];
          drop_sleeper(i);
          push_answer(efg_pkg::KIND_RELEASE, c.task_id, want,
                      c.op == efg_pkg::OP_TIMEOUT ?
                      efg_pkg::ST_TIMED_OUT : efg_pkg::ST_INTERRUPTED);
        end else push_answer(efg_pkg::KIND_CALLER, c.task_id, '0, efg_pkg::ST_WOULD_BLOCK);
      end
      efg_pkg::OP_DELETE: begin
        while (wait_cnt > 0) begin
          want = wait_mask[0];
          who = wait_task[0];
          drop_sleeper(0);
          push_answer(efg_pkg::KIND_RELEASE, who, want, efg_pkg::ST_REMOVED);
        end
        flag_word = '0;
        push_answer(efg_pkg::KIND_CALLER, c.task_id, '0, efg_pkg::ST_OK);
      end
      default: ;
    endcase
    if (expected_answers.size() > prior_cnt)
      expected_answers[expected_answers.size()-1].last = 1'b1;
  endfunction

  function automatic int short_or_long_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: hold each beat until accepted, then advance after a random gap.
  int send_gap = 0;
  always @(posedge clk) begin
    call_t c;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_call('{in_op, in_mask, in_wait_mode, in_task_id});
        send_gap = short_or_long_gap();
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!hold_sender && pending_calls.size() > 0) begin
          c = pending_calls.pop_front();
          in_valid <= 1'b1;
          in_op <= c.op; in_mask <= c.mask;
          in_wait_mode <= c.wait_mode; in_task_id <= c.task_id;
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation, drop on ready.
  int recv_gap = 0;
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, who=%0d", out_who);
        end else begin
          e = expected_answers.pop_front();
          if (out_kind !== e.kind || out_who !== e.who || out_granted_mask !== e.granted ||
              out_status !== e.status || out_flags_now !== e.flags_now ||
              out_sleepers !== e.sleepers || out_last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: k%0d w%0d g%h s%0d f%h n%0d l%0d",
                       e.kind, e.who, e.granted, e.status, e.flags_now, e.sleepers, e.last);
              $display("         got: k%0d w%0d g%h s%0d f%h n%0d l%0d",
                       out_kind, out_who, out_granted_mask, out_status, out_flags_now,
                       out_sleepers, out_last);
            end
          end
        end
        recv_gap = short_or_long_gap();
      end
      if (hold_receiver) out_ready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic add_call(logic [2:0] op, logic [31:0] mask, logic any, logic [7:0] id);
    pending_calls.push_back('{op, mask, any, id});
  endtask

  task automatic wait_drained();
    while (pending_calls.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Load the flag word through the register port; the block must be idle.
  task automatic load_flags(logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 2'(efg_pkg::REG_INITIAL_FLAGS * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    flag_word = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return $urandom & $urandom;
      default: return $urandom & 32'h0000_00FF << (8 * $urandom_range(0, 3));
    endcase
  endfunction

  // Random call, biased toward well-formed waits and posts over a small task pool.
  task automatic add_random_call();
    int r;
    logic [7:0] id;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    if (r < 30) add_call(efg_pkg::OP_POST, rand_mask(), 1'($urandom), id);
    else if (r < 45) add_call(efg_pkg::OP_PEND_NB, rand_mask(), 1'($urandom), id);
    else if (r < 78) add_call(efg_pkg::OP_PEND_BL, rand_mask(), 1'($urandom), id);
    else if (r < 86) add_call(efg_pkg::OP_TIMEOUT, $urandom, 1'($urandom), id);
    else if (r < 94) add_call(efg_pkg::OP_BREAK, $urandom, 1'($urandom), id);
    else if (r < 97) add_call(efg_pkg::OP_DELETE, $urandom, 1'($urandom), id);
    else add_call(3'($urandom_range(6, 7)), $urandom, 1'($urandom), id);
  endtask

  initial begin
    flag_word = '0;
    wait_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every op, extremes, empty masks, full queue, duplicates.
    load_flags(32'h0000_00F0);
    add_call(efg_pkg::OP_PEND_NB, 32'h0000_0030, 1'b0, 8'd1);
    add_call(efg_pkg::OP_PEND_NB, 32'h0000_0300, 1'b1, 8'd2);
    add_call(efg_pkg::OP_PEND_NB, 32'h0, 1'b1, 8'd3);
    add_call(efg_pkg::OP_PEND_BL, 32'h0, 1'b0, 8'd4);
    add_call(efg_pkg::OP_PEND_BL, 32'h0, 1'b1, 8'd5);
    for (int k = 0; k < 8; k++)
      add_call(efg_pkg::OP_PEND_BL, 32'h1 << (4 * k), k[0], 8'(k == 7 ? 5 : 250 + k));
    add_call(efg_pkg::OP_PEND_BL, 32'hFFFF_FFFF, 1'b0, 8'd255);
    add_call(efg_pkg::OP_TIMEOUT, 32'h0, 1'b0, 8'd5);
    add_call(efg_pkg::OP_BREAK, 32'h0, 1'b0, 8'd5);
    add_call(efg_pkg::OP_BREAK, 32'h0, 1'b0, 8'd99);
    add_call(efg_pkg::OP_POST, 32'hFFFF_FFFF, 1'b1, 8'd0);
    add_call(efg_pkg::OP_PEND_BL, 32'h8000_0000, 1'b0, 8'd7);
    add_call(3'd6, 32'hFFFF_FFFF, 1'b1, 8'd7);
    add_call(3'd7, 32'h0, 1'b0, 8'd7);
    add_call(efg_pkg::OP_DELETE, 32'h0, 1'b0, 8'd8);
    wait_drained();

    // Fill the queue and hold off the receiver so the input stalls.
    load_flags(32'hFFFF_FFFF);
    load_flags(32'h0);
    hold_receiver = 1'b1;
    for (int k = 0; k < 10; k++)
      add_call(efg_pkg::OP_PEND_BL, $urandom | 32'h1, 1'b0, 8'(k));
    add_call(efg_pkg::OP_POST, 32'hFFFF_FFFF, 1'b0, 8'd200);
    repeat (300) @(posedge clk);
    hold_receiver = 1'b0;
    wait_drained();

    // Random phases with varying initial flags; pause the sender once, in the fourth phase.
    for (int p = 0; p < 7; p++) begin
      load_flags(p == 0 ? 32'h0 : p == 1 ? 32'hFFFF_FFFF : $urandom);
      for (int k = 0; k < 50; k++) add_random_call();
      hold_sender = (p == 3);
      if (hold_sender) begin
        repeat (200) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/efg_pkg.sv
design/efg_front.sv
design/efg_back.sv
design/event_flag_group.sv
tb/testbench.sv
